/* rtl/core/bthk_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bthk_pkg
// Field widths and constants shared by the bounded top-k heap and its
// channel interfaces.
// ----------------------------------------------------------------------------
package bthk_pkg;

  localparam int CMD_W     = 2;
  localparam int DIST_IN_W = 31;
  localparam int DIST_W    = 32;
  localparam int COUNT_W   = 9;
  localparam int INDEX_W   = 8;

  // Distance 10.0 in unsigned Q4.28 marks an empty entry.
  localparam logic [DIST_W-1:0] EMPTY_DIST = 32'hA000_0000;

endpackage
`default_nettype wire

/* rtl/core/bthk_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bthk channel interfaces
// Valid/ready channels of the bounded top-k heap: the candidate command
// channel, the result channel and the heap size write channel.
// ----------------------------------------------------------------------------
interface bthk_cand_if #(parameter int ID_BITS = 24) ();
  import bthk_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [ID_BITS-1:0]   point_id;
  logic [DIST_IN_W-1:0] distance;
  logic [INDEX_W-1:0]   index;

  modport source (output valid, cmd, point_id, distance, index, input ready);
  modport sink (input valid, cmd, point_id, distance, index, output ready);
endinterface

interface bthk_result_if #(parameter int ID_BITS = 24) ();
  import bthk_pkg::*;

  logic               valid;
  logic               ready;
  logic               accepted;
  logic [COUNT_W-1:0] kept_count;
  logic [DIST_W-1:0]  worst_distance;
  logic [ID_BITS-1:0] entry_id;
  logic [DIST_W-1:0]  entry_distance;

  modport source (
    output valid, accepted, kept_count, worst_distance, entry_id, entry_distance,
    input ready
  );
  modport sink (
    input valid, accepted, kept_count, worst_distance, entry_id, entry_distance,
    output ready
  );
endinterface

interface bthk_cfg_if ();
  import bthk_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] value;

  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface
`default_nettype wire

/* rtl/core/bounded_top_k_heap_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_top_k_heap_core
// Command flow: a rejected insert or a no-op goes from S_IDLE to S_DONE, a
// read passes through S_READ, an accepted insert walks S_SIFT down at most
// floor(log2(heap size)) + 1 levels, and a clear runs S_CLEAR over every
// entry before S_DONE. One command at a time; the sift-down does one
// child-pair read and compare on the distance memory per cycle.
// After reset a clearing pass over every entry runs before a command is taken.
// ----------------------------------------------------------------------------
module bounded_top_k_heap_core #(
  parameter int CAPACITY = 256,
  parameter int ID_BITS  = 24
) (
  input  logic            clk,
  input  logic            rst,
  bthk_cfg_if.sink        cfg,
  bthk_cand_if.sink       cand,
  bthk_result_if.source   result
);
  import bthk_pkg::*;

  localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int POS_W   = COUNT_W;
  localparam int CHILD_W = COUNT_W + 1;

  localparam logic [COUNT_W-1:0] CAP_N     = COUNT_W'(CAPACITY);
  localparam logic [AW-1:0]      LAST_ADDR = AW'(CAPACITY - 1);

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_SIFT, S_READ, S_DONE} state_t;

  state_t               state;
  logic [COUNT_W-1:0]   heap_size;
  logic [COUNT_W-1:0]   kept;
  logic [DIST_W-1:0]    root_dist;
  logic [ID_BITS-1:0]   root_id;
  logic [AW-1:0]        clr_addr;
  logic                 clr_reply;
  logic [POS_W-1:0]     pos;
  logic [ID_BITS-1:0]   new_id;
  logic [DIST_IN_W-1:0] new_dist;
  logic                 res_acc;
  logic [ID_BITS-1:0]   res_eid;
  logic [DIST_W-1:0]    res_edist;

  logic                 out_valid;
  logic                 out_acc;
  logic [COUNT_W-1:0]   out_kept;
  logic [DIST_W-1:0]    out_worst;
  logic [ID_BITS-1:0]   out_eid;
  logic [DIST_W-1:0]    out_edist;

  logic [DIST_W-1:0]    dist_mem [CAPACITY];
  logic [ID_BITS-1:0]   id_mem [CAPACITY];
  logic [DIST_W-1:0]    dist_a;
  logic [DIST_W-1:0]    dist_b;
  logic [ID_BITS-1:0]   id_a;
  logic [ID_BITS-1:0]   id_b;

  logic [AW-1:0]        rd_a;
  logic [AW-1:0]        rd_b;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [DIST_W-1:0]    wr_dist;
  logic [ID_BITS-1:0]   wr_id;

  logic [COUNT_W-1:0]   used_n;
  logic [CHILD_W-1:0]   n_ext;
  logic [CHILD_W-1:0]   child_l;
  logic [CHILD_W-1:0]   child_r;
  logic                 left_end;
  logic                 right_ok;
  logic                 pick_right;
  logic [CHILD_W-1:0]   pick_idx;
  logic [POS_W-1:0]     pick_pos;
  logic [DIST_W-1:0]    pick_dist;
  logic [ID_BITS-1:0]   pick_id;
  logic                 sift_stop;
  logic                 cand_fire;

  assign cand.ready = (state == S_IDLE);
  assign cand_fire  = cand.valid && cand.ready;
  assign cfg.ready  = 1'b1;

  assign result.valid          = out_valid;
  assign result.accepted       = out_acc;
  assign result.kept_count     = out_kept;
  assign result.worst_distance = out_worst;
  assign result.entry_id       = out_eid;
  assign result.entry_distance = out_edist;

  always_comb begin
    if (heap_size == '0) begin
      used_n = COUNT_W'(1);
    end else if (32'(heap_size) > CAPACITY) begin
      used_n = CAP_N;
    end else begin
      used_n = heap_size;
    end
  end

  always_comb begin
    n_ext      = {1'b0, used_n};
    child_l    = {pos, 1'b1};
    child_r    = {pos, 1'b0} + CHILD_W'(2);
    left_end   = child_l >= n_ext;
    right_ok   = child_r < n_ext;
    pick_right = right_ok && !(dist_a > dist_b);
    pick_idx   = pick_right ? child_r : child_l;
    pick_pos   = pick_idx[POS_W-1:0];
    pick_dist  = pick_right ? dist_b : dist_a;
    pick_id    = pick_right ? id_b : id_a;
    sift_stop  = left_end || (pick_dist <= {1'b0, new_dist});
  end

  always_comb begin
    if (state == S_IDLE) begin
      rd_a = (cand.cmd == CMD_READ) ? AW'(cand.index) : AW'(1);
      rd_b = AW'(2);
    end else begin
      rd_a = AW'({pick_pos, 1'b1});
      rd_b = AW'({pick_pos, 1'b0} + CHILD_W'(2));
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_dist = EMPTY_DIST;
    wr_id   = '0;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
    end else if (state == S_SIFT) begin
      wr_en   = 1'b1;
      wr_addr = AW'(pos);
      if (sift_stop) begin
        wr_dist = {1'b0, new_dist};
        wr_id   = new_id;
      end else begin
        wr_dist = pick_dist;
        wr_id   = pick_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dist_mem[wr_addr] <= wr_dist;
      id_mem[wr_addr]   <= wr_id;
    end
    dist_a <= dist_mem[rd_a];
    dist_b <= dist_mem[rd_b];
    id_a   <= id_mem[rd_a];
    id_b   <= id_mem[rd_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      heap_size <= COUNT_W'(256);
      kept      <= '0;
      root_dist <= EMPTY_DIST;
      root_id   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        heap_size <= cfg.value;
      end
      if (result.valid && result.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cand_fire) begin
            new_id    <= cand.point_id;
            new_dist  <= cand.distance;
            res_acc   <= (cand.cmd == CMD_INSERT) && ({1'b0, cand.distance} < root_dist);
            res_eid   <= '0;
            res_edist <= EMPTY_DIST;
            unique case (cand.cmd)
              CMD_CLEAR: begin
                state     <= S_CLEAR;
                clr_addr  <= '0;
                clr_reply <= 1'b1;
                kept      <= '0;
                root_dist <= EMPTY_DIST;
                root_id   <= '0;
              end
              CMD_INSERT: begin
                if ({1'b0, cand.distance} >= root_dist) begin
                  state <= S_DONE;
                end else begin
                  pos     <= '0;
                  state   <= S_SIFT;
                  if (root_id == '0 && kept < used_n) begin
                    kept <= kept + COUNT_W'(1);
                  end
                end
              end
              CMD_READ: begin
                if ({1'b0, cand.index} < used_n) begin
                  state <= S_READ;
                end else begin
                  state <= S_DONE;
                end
              end
              CMD_NOP: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= clr_reply ? S_DONE : S_IDLE;
          end
        end
        S_SIFT: begin
          if (pos == '0) begin
            root_dist <= wr_dist;
            root_id   <= wr_id;
          end
          if (sift_stop) begin
            state <= S_DONE;
          end else begin
            pos <= pick_pos;
          end
        end
        S_READ: begin
          res_eid   <= id_a;
          res_edist <= dist_a;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_acc   <= res_acc;
            out_kept  <= kept;
            out_worst <= root_dist;
            out_eid   <= res_eid;
            out_edist <= res_edist;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire
